[rtl/chte_pkg.sv]
// Shared types, widths and constants of the chained hash table engine.
`default_nettype none
package chte_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_PORT_W   = 32;
  localparam int BCNT_W       = 7;
  localparam int MAXE_W       = 9;
  localparam int CNT_W        = 9;
  localparam int CFG_W        = 9;
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int BCNT_RESET   = 31;

  localparam int POOL_ENTRIES_DEF = 256;
  localparam int MAX_BUCKETS_DEF  = 127;
  localparam int VALUE_BITS_DEF   = 32;

  localparam logic [KEY_W-1:0] HASH_MUL = 32'd278;
  localparam logic [KEY_W-1:0] HASH_ADD = 32'd12345;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_SET    = 2'd2,
    ACT_DEL    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_BUCKETS     = 1'b0,
    CFG_MAX_ENTRIES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic    load;
    logic    hash;
    logic    div_step;
    logic    head_load;
    logic    walk;
    logic    rd_free;
    logic    alloc;
    logic    unlink;
    logic    free_push;
    logic    set_val;
    logic    res_load;
    status_t res_status;
    logic    res_rdval;
  } chte_cmd_t;

  typedef struct packed {
    action_t action;
    logic    div_last;
    logic    head_nil;
    logic    key_match;
    logic    walk_stop;
    logic    hit;
    logic    room;
  } chte_sts_t;

endpackage
`default_nettype wire

[rtl/chte_datapath.sv]
// Datapath: hash, remainder unit, bucket heads, entry pool and free list.
`default_nettype none
module chte_datapath
  import chte_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [1:0]            in_action,
  input  wire logic [KEY_W-1:0]      in_key,
  input  wire logic [VAL_PORT_W-1:0] in_value,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire chte_cmd_t             cmd,
  output chte_sts_t                  sts,
  output logic [1:0]                 out_status,
  output logic [VAL_PORT_W-1:0]      out_read_value,
  output logic [CNT_W-1:0]           out_entry_count
);

  localparam int LW   = $clog2(POOL_ENTRIES + 1);
  localparam int IW   = $clog2(POOL_ENTRIES);
  localparam int BW   = $clog2(MAX_BUCKETS + 1);
  localparam int HW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW   = (LW > MAXE_W) ? LW : MAXE_W;
  localparam int EW   = (BW > BCNT_W) ? BW : BCNT_W;
  localparam int TOPB = (MAX_BUCKETS % 2 == 1) ? MAX_BUCKETS : MAX_BUCKETS - 1;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  logic [BCNT_W-1:0]     bcnt_r;
  logic [MAXE_W-1:0]     maxe_r;
  action_t               act_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_W-1:0]      prod_r;
  logic [BW-1:0]         div_r;
  logic [BW-1:0]         rem_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [LW-1:0]         cur_r;
  logic [LW-1:0]         prev_r;
  logic [LW-1:0]         head_r;
  logic [LW-1:0]         steps_r;
  logic                  hit_r;
  logic [LW-1:0]         free_head_r;
  logic [LW-1:0]         fresh_r;
  logic [LW-1:0]         count_r;
  logic [1:0]            res_status_r;
  logic [VAL_PORT_W-1:0] res_val_r;
  logic [MAX_BUCKETS-1:0] head_vld_r;

  logic [LW-1:0]         head_mem [MAX_BUCKETS];
  logic [KEY_W-1:0]      key_mem  [POOL_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [POOL_ENTRIES];
  logic [LW-1:0]         link_mem [POOL_ENTRIES];
  logic [LW-1:0]         head_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [LW-1:0]         link_q;

  logic [EW-1:0]         b_ext;
  logic [EW-1:0]         eff;
  logic [BW:0]           trial;
  logic [HW-1:0]         bucket;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         cur_idx;
  logic [IW-1:0]         fh_idx;
  logic [LW-1:0]         head_init;
  logic                  head_we;
  logic [LW-1:0]         head_wd;
  logic                  link_we;
  logic [IW-1:0]         link_wa;
  logic [LW-1:0]         link_wd;
  logic [IW-1:0]         val_wa;

  assign b_ext     = EW'(bcnt_r | BCNT_W'(1));
  assign eff       = (b_ext > EW'(TOPB)) ? EW'(TOPB) : b_ext;
  assign trial     = {rem_r, prod_r[KEY_W-1]};
  assign bucket    = rem_r[HW-1:0];
  assign cur_idx   = cur_r[IW-1:0];
  assign fh_idx    = free_head_r[IW-1:0];
  assign rd_addr   = cmd.rd_free ? fh_idx : cur_idx;
  assign head_init = head_vld_r[bucket] ? head_q : NIL;

  always_comb begin
    head_we = cmd.alloc || (cmd.unlink && prev_r == NIL);
    head_wd = cmd.alloc ? free_head_r : link_q;
    link_we = cmd.alloc || cmd.free_push || (cmd.unlink && prev_r != NIL);
    link_wa = cmd.alloc ? fh_idx : (cmd.free_push ? cur_idx : prev_r[IW-1:0]);
    link_wd = cmd.alloc ? head_r : (cmd.free_push ? free_head_r : link_q);
    val_wa  = cmd.alloc ? fh_idx : cur_idx;
  end

  always_comb begin
    sts.action    = act_r;
    sts.div_last  = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
    sts.head_nil  = head_init == NIL;
    sts.key_match = key_q == key_r;
    sts.walk_stop = link_q == NIL || steps_r == LW'(POOL_ENTRIES - 1);
    sts.hit       = hit_r;
    sts.room      = free_head_r != NIL &&
                    !(maxe_r != '0 && CW'(count_r) >= CW'(maxe_r));
  end

  always_ff @(posedge clk) begin
    head_q <= head_mem[bucket];
    if (head_we) begin
      head_mem[bucket] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[rd_addr];
    if (cmd.alloc) begin
      key_mem[fh_idx] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    val_q <= val_mem[rd_addr];
    if (cmd.alloc || cmd.set_val) begin
      val_mem[val_wa] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[rd_addr];
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r      <= BCNT_W'(BCNT_RESET);
      maxe_r      <= '0;
      head_vld_r  <= '0;
      free_head_r <= '0;
      fresh_r     <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BUCKETS:     bcnt_r <= cfg_wdata[BCNT_W-1:0];
          CFG_MAX_ENTRIES: maxe_r <= cfg_wdata[MAXE_W-1:0];
          default:         maxe_r <= maxe_r;
        endcase
      end
      if (head_we) begin
        head_vld_r[bucket] <= 1'b1;
      end
      if (cmd.alloc) begin
        count_r <= count_r + LW'(1);
        if (free_head_r == fresh_r) begin
          free_head_r <= fresh_r + LW'(1);
          fresh_r     <= fresh_r + LW'(1);
        end else begin
          free_head_r <= link_q;
        end
      end else if (cmd.free_push) begin
        count_r     <= count_r - LW'(1);
        free_head_r <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      key_r <= in_key;
      val_r <= VALUE_BITS'(in_value);
    end
    if (cmd.hash) begin
      prod_r    <= KEY_W'(key_r * HASH_MUL + HASH_ADD);
      div_r     <= BW'(eff);
      rem_r     <= '0;
      div_cnt_r <= '0;
      hit_r     <= 1'b0;
    end
    if (cmd.div_step) begin
      prod_r    <= {prod_r[KEY_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      if (trial >= {1'b0, div_r}) begin
        rem_r <= BW'(trial - {1'b0, div_r});
      end else begin
        rem_r <= BW'(trial);
      end
    end
    if (cmd.head_load) begin
      cur_r   <= head_init;
      head_r  <= head_init;
      prev_r  <= NIL;
      steps_r <= '0;
    end
    if (cmd.walk) begin
      if (key_q == key_r) begin
        hit_r <= 1'b1;
      end else begin
        prev_r  <= cur_r;
        cur_r   <= link_q;
        steps_r <= steps_r + LW'(1);
      end
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_val_r    <= cmd.res_rdval ? VAL_PORT_W'(val_q) : '0;
    end
  end

  assign out_status      = res_status_r;
  assign out_read_value  = res_val_r;
  assign out_entry_count = CNT_W'(count_r);

endmodule
`default_nettype wire

[rtl/chte_ctrl.sv]
// Controller state machine that sequences hash, chain walk and update.
`default_nettype none
module chte_ctrl
  import chte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire chte_sts_t sts,
  output chte_cmd_t      cmd,
  output logic           busy,
  output logic           out_strobe
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_HASH   = 12'b0000_0000_0010,
    S_DIV    = 12'b0000_0000_0100,
    S_HEAD   = 12'b0000_0000_1000,
    S_HEADW  = 12'b0000_0001_0000,
    S_RD     = 12'b0000_0010_0000,
    S_CMP    = 12'b0000_0100_0000,
    S_RES    = 12'b0000_1000_0000,
    S_FRD    = 12'b0001_0000_0000,
    S_FWR    = 12'b0010_0000_0000,
    S_UNLINK = 12'b0100_0000_0000,
    S_FREE   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !done_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_HEAD;
      end
      S_HEAD:  state_nxt = S_HEADW;
      S_HEADW: begin
        cmd.head_load = 1'b1;
        state_nxt     = sts.head_nil ? S_RES : S_RD;
      end
      S_RD:  state_nxt = S_CMP;
      S_CMP: begin
        cmd.walk  = 1'b1;
        state_nxt = (sts.key_match || sts.walk_stop) ? S_RES : S_RD;
      end
      S_RES: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_IDLE;
        done_nxt     = 1'b1;
        unique case (sts.action)
          ACT_LOOKUP: begin
            cmd.res_status = sts.hit ? ST_OK : ST_MISS;
            cmd.res_rdval  = sts.hit;
          end
          ACT_DEL: begin
            cmd.res_status = ST_MISS;
            if (sts.hit) begin
              cmd.res_load = 1'b0;
              done_nxt     = 1'b0;
              state_nxt    = S_UNLINK;
            end
          end
          ACT_ADD, ACT_SET: begin
            if (sts.hit) begin
              cmd.set_val    = sts.action == ACT_SET;
              cmd.res_status = (sts.action == ACT_SET) ? ST_OK : ST_DUP;
            end else if (sts.room) begin
              cmd.res_load = 1'b0;
              done_nxt     = 1'b0;
              state_nxt    = S_FRD;
            end else begin
              cmd.res_status = ST_FULL;
            end
          end
          default: cmd.res_status = ST_MISS;
        endcase
      end
      S_FRD: begin
        cmd.rd_free = 1'b1;
        state_nxt   = S_FWR;
      end
      S_FWR: begin
        cmd.alloc      = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        done_nxt       = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_FREE;
      end
      S_FREE: begin
        cmd.free_push  = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        done_nxt       = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE) || done_r;
  assign out_strobe = done_r;

endmodule
`default_nettype wire

[rtl/chained_hash_table_engine_top.sv]
// Top level of the chained hash table engine: controller, datapath, checks.
`default_nettype none
// One request per start pulse while busy is low. The bucket remainder takes
// one bit per cycle; each step of the chain walk that follows reads the entry
// pool memory and then compares the registered key. The result strobe rises
// after the hash, the remainder steps, the bucket head read and the walk; an
// insert first reads the free list head and allocates, a delete first unlinks
// and frees the entry. Busy drops right after the strobe, which is high for
// one cycle only and cannot be held off. Configuration writes land at once.
module chained_hash_table_engine_top
  import chte_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_action,
  input  wire logic [KEY_W-1:0]      in_key,
  input  wire logic [VAL_PORT_W-1:0] in_value,
  output logic                       out_strobe,
  output logic [1:0]                 out_status,
  output logic [VAL_PORT_W-1:0]      out_read_value,
  output logic [CNT_W-1:0]           out_entry_count,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  chte_cmd_t cmd;
  chte_sts_t sts;

  chte_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  chte_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .MAX_BUCKETS  (MAX_BUCKETS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("busy held after result strobe");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> $stable(out_entry_count))
    else $error("entry count moved on a refused request");
`endif

endmodule
`default_nettype wire
